>>> hw/rtl/jet_pkg.sv
// shared types and constants for the julia escape-time block
`timescale 1ns / 1ps

package jet_pkg;

  // fixed-point format: signed Q6.26
  localparam int unsigned FRAC_BITS = 26;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned PIXEL_W   = 10;
  localparam int unsigned ITER_W    = 10;
  localparam int unsigned REG_IDX_W = 3;

  // modulus squared limit 4 in Q12.52
  localparam logic [63:0] ESCAPE_LIMIT = 64'h0040_0000_0000_0000;

  // register reset values
  localparam logic signed [31:0] RST_MIN_RE   = -32'sd100663296;
  localparam logic signed [31:0] RST_MAX_IM   = 32'sd67108864;
  localparam logic signed [31:0] RST_STEP_RE  = 32'sd196800;
  localparam logic signed [31:0] RST_STEP_IM  = 32'sd131200;
  localparam logic signed [31:0] RST_CONST_RE = -32'sd39325958;
  localparam logic signed [31:0] RST_CONST_IM = 32'sd31809651;
  localparam logic [9:0]         RST_MAX_ITER = 10'd100;

  // register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_RE   = 3'd0,
    REG_MAX_IM   = 3'd1,
    REG_STEP_RE  = 3'd2,
    REG_STEP_IM  = 3'd3,
    REG_CONST_RE = 3'd4,
    REG_CONST_IM = 3'd5,
    REG_MAX_ITER = 3'd6
  } jet_reg_t;

  // configuration bundle
  typedef struct packed {
    logic signed [31:0] min_re;
    logic signed [31:0] max_im;
    logic signed [31:0] step_re;
    logic signed [31:0] step_im;
    logic signed [31:0] const_re;
    logic signed [31:0] const_im;
    logic [ITER_W-1:0]  max_iter;
  } jet_cfg_t;

  // complex start point
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } jet_point_t;

  // saturate a 44-bit signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sh000_7FFF_FFFF;
    lo = -44'sh000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

>>> hw/rtl/jet_front.sv
// pixel to start point mapping: product stage, then offset add and saturation
`timescale 1ns / 1ps

module jet_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  jet_pkg::jet_cfg_t                cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [jet_pkg::PIXEL_W-1:0]      in_pixel_x,
  input  logic [jet_pkg::PIXEL_W-1:0]      in_pixel_y,
  output logic                             pt_valid,
  input  logic                             pt_ready,
  output jet_pkg::jet_point_t              pt_data
);
  import jet_pkg::*;

  logic                s1_valid_r;
  logic signed [42:0]  prod_re_r;
  logic signed [42:0]  prod_im_r;
  logic signed [42:0]  prod_re;
  logic signed [42:0]  prod_im;
  logic signed [43:0]  sum_re;
  logic signed [43:0]  sum_im;
  logic                s1_take;

  // pixel offsets scaled by the step registers
  assign prod_re = $signed({1'b0, in_pixel_x}) * cfg.step_re;
  assign prod_im = $signed({1'b0, in_pixel_y}) * cfg.step_im;

  assign s1_take  = in_valid && in_ready;
  assign in_ready = !s1_valid_r || pt_ready;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (s1_take) begin
      prod_re_r <= prod_re;
      prod_im_r <= prod_im;
    end
  end

  // offset add or subtract and saturation into the queue
  assign sum_re = 44'(cfg.min_re) + 44'(prod_re_r);
  assign sum_im = 44'(cfg.max_im) - 44'(prod_im_r);

  assign pt_valid   = s1_valid_r;
  assign pt_data.re = sat32(sum_re);
  assign pt_data.im = sat32(sum_im);

endmodule

>>> hw/rtl/jet_queue.sv
// small fifo of start points between front and iteration engine
`timescale 1ns / 1ps

module jet_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  jet_pkg::jet_point_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output jet_pkg::jet_point_t pop_data
);
  import jet_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  jet_point_t          mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/jet_iter.sv
// escape-time iteration engine with result register
`timescale 1ns / 1ps

module jet_iter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  jet_pkg::jet_cfg_t           cfg,
  input  logic                        pt_valid,
  output logic                        pt_ready,
  input  jet_pkg::jet_point_t         pt_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_escaped,
  output logic [jet_pkg::ITER_W-1:0]  out_escape_index
);
  import jet_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_STEP = 4'b0100,
    S_DONE = 4'b1000
  } jet_state_t;

  jet_state_t          state_r;
  jet_state_t          state_nxt;
  logic signed [31:0]  re_r;
  logic signed [31:0]  im_r;
  logic signed [63:0]  rr_r;
  logic signed [63:0]  ii_r;
  logic signed [63:0]  ri_r;
  logic [ITER_W-1:0]   k_r;
  logic                first_r;
  logic                esc_r;
  logic [ITER_W-1:0]   idx_r;
  logic                out_valid_r;
  logic                out_escaped_r;
  logic [ITER_W-1:0]   out_index_r;

  logic signed [63:0]  diff;
  logic signed [43:0]  nre;
  logic signed [43:0]  nim;
  logic [63:0]         mag;
  logic                escape_hit;
  logic                last_iter;
  logic                out_load;

  // update terms from the registered products
  assign diff = rr_r - ii_r;
  assign nre  = 44'(signed'(diff[63:26])) + 44'(cfg.const_re);
  assign nim  = 44'(signed'(ri_r[63:25])) + 44'(cfg.const_im);

  // escape test on the squares of the last update
  assign mag        = unsigned'(rr_r) + unsigned'(ii_r);
  assign escape_hit = !first_r && (mag > ESCAPE_LIMIT);
  assign last_iter  = !first_r && (({1'b0, k_r} + 11'd1) == {1'b0, cfg.max_iter});

  assign pt_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (pt_valid) begin
          state_nxt = (cfg.max_iter == '0) ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        state_nxt = (escape_hit || last_iter) ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath: load, multiply, update
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        re_r    <= pt_data.re;
        im_r    <= pt_data.im;
        k_r     <= '0;
        first_r <= 1'b1;
        esc_r   <= 1'b0;
        idx_r   <= '0;
      end
      S_MUL: begin
        rr_r <= re_r * re_r;
        ii_r <= im_r * im_r;
        ri_r <= re_r * im_r;
      end
      S_STEP: begin
        if (escape_hit) begin
          esc_r <= 1'b1;
          idx_r <= k_r;
        end else if (!last_iter) begin
          if (!first_r) begin
            k_r <= k_r + 1'b1;
          end
          first_r <= 1'b0;
          re_r    <= sat32(nre);
          im_r    <= sat32(nim);
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_escaped_r <= esc_r;
      out_index_r   <= idx_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_escaped      = out_escaped_r;
  assign out_escape_index = out_index_r;

endmodule

>>> hw/rtl/julia_escape_time.sv
// top level: config registers, front mapper, point queue, iteration engine
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid/in_ready, in_pixel_x, in_pixel_y | in
//   result  | out_valid/out_ready, out_escaped,       | out
//           | out_escape_index                        |
//   config  | cfg_we, cfg_index, cfg_wdata            | in
//
// a pixel is registered in the front mapper, then written into the point queue
// the engine holds a pixel until its result loads, running the multiply/update
// loop until escape or max_iter, or no loop at all when max_iter is 0
// reset clears all control state and loads the register defaults, no sweep
// the front keeps taking pixels while the engine iterates and while a result
// waits to be taken, until the queue fills
`timescale 1ns / 1ps

module julia_escape_time #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [jet_pkg::PIXEL_W-1:0]      in_pixel_x,
  input  logic [jet_pkg::PIXEL_W-1:0]      in_pixel_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_escaped,
  output logic [jet_pkg::ITER_W-1:0]       out_escape_index,
  input  logic                             cfg_we,
  input  logic [jet_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [jet_pkg::COORD_W-1:0]      cfg_wdata
);
  import jet_pkg::*;

  jet_cfg_t    cfg_r;
  logic        fq_valid;
  logic        fq_ready;
  jet_point_t  fq_data;
  logic        qe_valid;
  logic        qe_ready;
  jet_point_t  qe_data;

  // configuration register bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_re   <= RST_MIN_RE;
      cfg_r.max_im   <= RST_MAX_IM;
      cfg_r.step_re  <= RST_STEP_RE;
      cfg_r.step_im  <= RST_STEP_IM;
      cfg_r.const_re <= RST_CONST_RE;
      cfg_r.const_im <= RST_CONST_IM;
      cfg_r.max_iter <= RST_MAX_ITER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_RE:   cfg_r.min_re   <= cfg_wdata;
        REG_MAX_IM:   cfg_r.max_im   <= cfg_wdata;
        REG_STEP_RE:  cfg_r.step_re  <= cfg_wdata;
        REG_STEP_IM:  cfg_r.step_im  <= cfg_wdata;
        REG_CONST_RE: cfg_r.const_re <= cfg_wdata;
        REG_CONST_IM: cfg_r.const_im <= cfg_wdata;
        REG_MAX_ITER: cfg_r.max_iter <= cfg_wdata[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // pixel mapping
  jet_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .pt_valid   (fq_valid),
    .pt_ready   (fq_ready),
    .pt_data    (fq_data)
  );

  // decoupling queue
  jet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qe_valid),
    .pop_ready  (qe_ready),
    .pop_data   (qe_data)
  );

  // iteration engine
  jet_iter u_iter (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .pt_valid         (qe_valid),
    .pt_ready         (qe_ready),
    .pt_data          (qe_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_escaped      (out_escaped),
    .out_escape_index (out_escape_index)
  );

endmodule
